// ----- hw/rtl/ibs_pkg.sv -----
// insulation bridge sequencer: shared types, constants and helper functions
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps

package ibs_pkg;

    localparam int CODE_W     = 16;
    localparam int VOLT_W     = 16;
    localparam int RES_W      = 32;
    localparam int DIV_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int QDEPTH     = 2;

    // adc full scale and q16 scale factors
    localparam logic [15:0] CHAN_FS = 16'd61440;
    localparam logic [15:0] Q_PACK  = 16'd58528;
    localparam logic [15:0] Q_AUX   = 16'd26504;
    localparam logic [15:0] Q_LOW   = 16'd29264;
    localparam logic [15:0] Q_HIGH  = 16'd58528;

    localparam logic [15:0] GAIN_RESET   = 16'd1000;
    localparam logic [15:0] OFFSET_RESET = 16'd0;
    localparam logic [15:0] LEAK_RESET   = 16'd2000;
    localparam logic [15:0] PREV_RESET   = 16'd300;
    localparam logic [15:0] LEAK_INHIBIT = 16'd20000;
    localparam logic [15:0] PACK_MIN     = 16'd500;
    localparam logic [15:0] F1_LO        = 16'd8000;
    localparam logic [15:0] F1_HI        = 16'd12000;
    localparam logic [15:0] F2_HI        = 16'd16000;

    // floor(x / 1000) for any 32-bit x as (x * recip) >> shift
    localparam logic [28:0] PERMILLE_RECIP = 29'd274877907;
    localparam int          PERMILLE_SHIFT = 38;

    localparam logic [31:0] UN_HI     = 32'd1570;
    localparam logic [31:0] UN_HI_ADJ = 32'd80;
    localparam logic [31:0] UN_LO     = 32'd160;
    localparam logic [31:0] UN_LO_ADJ = 32'd60;

    localparam logic [14:0] SOLVE_NUM = 15'd25006;
    localparam logic [3:0]  SOLVE_DEN = 4'd10;

    typedef enum logic [3:0] {
        RELAY_POS    = 4'h2,
        RELAY_NEG    = 4'h8,
        RELAY_BRIDGE = 4'hA,
        RELAY_OPEN   = 4'hF
    } t_relay;

    typedef enum logic [1:0] {
        PH_TOTAL     = 2'd0,
        PH_BRIDGE    = 2'd1,
        PH_REMEASURE = 2'd2,
        PH_LEG       = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN   = 2'd0,
        CFG_OFFSET = 2'd1,
        CFG_ENABLE = 2'd2
    } t_cfg_reg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHAN,
        S_CHAN_WAIT,
        S_P0_SCALE,
        S_P0_GAIN,
        S_P0_WAIT,
        S_P0_FIN,
        S_LEGS,
        S_P1_FIN,
        S_P2_FIN,
        S_P3_PREP,
        S_P3_MUL,
        S_P3_CMP,
        S_P3_SOLVE,
        S_P3_SOLVE_WAIT,
        S_P3_FACT,
        S_P3_AVG,
        S_P3_AVG_WAIT,
        S_P3_SMOOTH,
        S_EMIT
    } t_seq_state;

    typedef struct packed {
        logic [CODE_W-1:0] code_a;
        logic [CODE_W-1:0] code_b;
        logic [CODE_W-1:0] code_c;
        logic [CODE_W-1:0] code_d;
        logic              ext_inhibit;
    } t_item;

    // correction factor in q16
    function automatic logic [16:0] factor_q16(input logic [1:0] code);
        logic [16:0] f;
        case (code)
            2'd1:    f = 17'd91750;
            2'd2:    f = 17'd117965;
            default: f = 17'd65536;
        endcase
        return f;
    endfunction

endpackage

// ----- hw/rtl/ibs_if.sv -----
// insulation bridge sequencer: sample, result and configuration channels
// depends on ibs_pkg
`timescale 1ns / 1ps

interface ibs_in_if;
    import ibs_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_a;
    logic [CODE_W-1:0] code_b;
    logic [CODE_W-1:0] code_c;
    logic [CODE_W-1:0] code_d;
    logic              contactor_closed;
    logic              charger_plugged;
    modport source(output valid, code_a, code_b, code_c, code_d, contactor_closed,
                   charger_plugged, input ready);
    modport sink(input valid, code_a, code_b, code_c, code_d, contactor_closed,
                 charger_plugged, output ready);
endinterface

interface ibs_out_if;
    import ibs_pkg::*;
    logic              valid;
    logic              ready;
    logic [3:0]        relay_pattern;
    logic [1:0]        phase_done;
    logic [VOLT_W-1:0] pack_voltage;
    logic [VOLT_W-1:0] heater_voltage;
    logic [VOLT_W-1:0] precharge_voltage;
    logic [VOLT_W-1:0] insulation_kohm;
    modport source(output valid, relay_pattern, phase_done, pack_voltage, heater_voltage,
                   precharge_voltage, insulation_kohm, input ready);
    modport sink(input valid, relay_pattern, phase_done, pack_voltage, heater_voltage,
                 precharge_voltage, insulation_kohm, output ready);
endinterface

interface ibs_cfg_if;
    import ibs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/insulation_bridge_sequencer_top.sv -----
// Insulation bridge sequencer. Each sample request carries four adc codes taken under the
// relay pattern of the previous result; the block runs a four-phase cycle (voltages, bridge,
// re-measure, leg switched in) and returns one result per request with the next relay pattern.
// A two-entry queue sits between the request side and the sequencer and a result register
// sits on the output, so a new request is taken while a result waits. The leg phase takes
// longest when the leg is solved: that solve runs on a 48-step divider (one quotient bit a
// cycle), while the adc scaling, the gain calibration and the average use shift-add folding
// and reciprocal multiplies.
// Configuration writes are always taken and must only arrive while the block is idle.
// depends on ibs_pkg, ibs_if, ibs_front, ibs_div, ibs_back
`timescale 1ns / 1ps

module insulation_bridge_sequencer_top #(
    parameter int AVG_LEN  = 3,
    parameter int ADC_BITS = 15
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ibs_in_if.sink    i_in,
    ibs_cfg_if.sink   i_cfg,
    ibs_out_if.source o_out
);
    import ibs_pkg::*;

    logic [15:0] r_gain;
    logic [15:0] r_offset;
    logic        r_enable;
    t_item       w_item;
    logic        w_item_valid;
    logic        w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_offset <= OFFSET_RESET;
            r_enable <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_GAIN:   r_gain   <= i_cfg.data;
                CFG_OFFSET: r_offset <= i_cfg.data;
                CFG_ENABLE: r_enable <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    ibs_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_pop        (w_pop)
    );

    ibs_back #(
        .AVG_LEN  (AVG_LEN),
        .ADC_BITS (ADC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_pop        (w_pop),
        .i_gain       (r_gain),
        .i_offset     (r_offset),
        .i_enable     (r_enable),
        .o_out        (o_out)
    );

`ifndef SYNTHESIS
    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_item_valid)
        else $error("sequencer popped an empty queue");

    a_bridge_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.phase_done == PH_BRIDGE) |-> o_out.relay_pattern == RELAY_BRIDGE)
        else $error("bridge phase result without bridge relay pattern");

    a_leg_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.phase_done == PH_LEG) |-> o_out.relay_pattern == RELAY_OPEN)
        else $error("leg phase result did not open all relays");

    a_inhibit_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.phase_done == PH_TOTAL) && (o_out.relay_pattern == RELAY_OPEN)
        |-> o_out.insulation_kohm == LEAK_INHIBIT)
        else $error("inhibited cycle without default insulation value");
`endif

endmodule

// ----- hw/rtl/ibs_front.sv -----
// insulation bridge sequencer front end: takes sample requests, masks the adc
// codes, flags external inhibits and queues them; depends on ibs_pkg, ibs_if
`timescale 1ns / 1ps

module ibs_front #(
    parameter int ADC_BITS = 15
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ibs_in_if.sink         i_in,
    output ibs_pkg::t_item o_item,
    output logic           o_item_valid,
    input  logic           i_pop
);
    import ibs_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [CODE_W-1:0] ADC_MASK = CODE_W'((32'd1 << ADC_BITS) - 32'd1);

    t_item            r_q [QDEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    t_item            w_item;
    logic             w_push;

    always_comb begin
        w_item.code_a      = i_in.code_a & ADC_MASK;
        w_item.code_b      = i_in.code_b & ADC_MASK;
        w_item.code_c      = i_in.code_c & ADC_MASK;
        w_item.code_d      = i_in.code_d & ADC_MASK;
        w_item.ext_inhibit = i_in.contactor_closed | i_in.charger_plugged;
    end

    assign i_in.ready   = (r_cnt != CNT_W'(QDEPTH));
    assign w_push       = i_in.valid & i_in.ready;
    assign o_item       = r_q[r_rd];
    assign o_item_valid = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
    end

endmodule

// ----- hw/rtl/ibs_div.sv -----
// insulation bridge sequencer: restoring divider for the bridge solve, one quotient bit a cycle
// depends on ibs_pkg
`timescale 1ns / 1ps

module ibs_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ibs_pkg::DIV_W-1:0] i_dividend,
    input  logic [ibs_pkg::DIV_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [ibs_pkg::DIV_W-1:0] o_quotient
);
    import ibs_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W:0]   w_shift;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    assign w_shift    = {r_rem, r_quo[DIV_W-1]};
    assign w_diff     = w_shift - {1'b0, r_div};
    assign w_ge       = (w_shift >= {1'b0, r_div});
    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

endmodule

// ----- hw/rtl/ibs_back.sv -----
// insulation bridge sequencer back end: phase sequencer, bridge solve,
// averaging and result register; depends on ibs_pkg, ibs_if, ibs_div
`timescale 1ns / 1ps

module ibs_back #(
    parameter int AVG_LEN  = 3,
    parameter int ADC_BITS = 15
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ibs_pkg::t_item         i_item,
    input  logic                   i_item_valid,
    output logic                   o_pop,
    input  logic [15:0]            i_gain,
    input  logic [15:0]            i_offset,
    input  logic                   i_enable,
    ibs_out_if.source              o_out
);
    import ibs_pkg::*;

    localparam logic [15:0] ADC_MASK = 16'((32'd1 << ADC_BITS) - 32'd1);
    localparam logic [31:0] ADC_MASK32 = {16'd0, ADC_MASK};
    localparam int CNT_W = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
    localparam int SUM_W = RES_W + $clog2(AVG_LEN + 1);
    localparam logic [CNT_W-1:0] AVG_LAST = CNT_W'(AVG_LEN - 1);
    // averages at or above this sum saturate; below it the sum fits 19 bits
    localparam logic [SUM_W-1:0] AVG_SAT = SUM_W'(64'd65536 * AVG_LEN);
    localparam logic [24:0] AVG_RECIP = 25'((32'd16777216 + AVG_LEN - 1) / AVG_LEN);

    t_seq_state r_state, n_state;

    // sequencer state carried between items
    t_phase            r_phase;
    logic [1:0]        r_factor;
    logic              r_neg_side;
    logic [RES_W-1:0]  r_bal_neg;
    logic [RES_W-1:0]  r_bal_pos;
    logic [RES_W-1:0]  r_pos_leg;
    logic [RES_W-1:0]  r_neg_leg;
    logic [RES_W-1:0]  r_pending;
    logic [SUM_W-1:0]  r_avg_sum;
    logic [CNT_W-1:0]  r_avg_cnt;
    logic [VOLT_W-1:0] r_leak_out;
    logic [VOLT_W-1:0] r_leak_prev;
    logic [VOLT_W-1:0] r_held_pack;
    logic [VOLT_W-1:0] r_held_heater;
    logic [VOLT_W-1:0] r_held_prech;

    // per-item working registers
    t_item             r_item;
    t_phase            r_done;
    t_relay            r_relay;
    logic [1:0]        r_sel;
    logic [31:0]       r_chan_prod;
    logic [15:0]       r_chan_a;
    logic [15:0]       r_chan_x;
    logic [15:0]       r_chan_d;
    logic [15:0]       r_raw;
    logic [31:0]       r_gain_prod;
    logic [31:0]       r_scaled;
    logic [RES_W-1:0]  r_un;
    logic [RES_W-1:0]  r_u2;
    logic [RES_W-1:0]  r_unp;
    logic [RES_W-1:0]  r_upp;
    logic              r_rise;
    logic [RES_W-1:0]  r_p0;
    logic [RES_W-1:0]  r_p1;
    logic [RES_W-1:0]  r_p2;
    logic [RES_W-1:0]  r_num;
    logic [RES_W-1:0]  r_den;
    logic              r_solve;
    logic [SUM_W-1:0]  r_avg_fin;

    // result register
    logic              r_out_valid;
    t_relay            r_out_relay;
    logic [1:0]        r_out_phase;
    logic [VOLT_W-1:0] r_out_pack;
    logic [VOLT_W-1:0] r_out_heater;
    logic [VOLT_W-1:0] r_out_prech;
    logic [VOLT_W-1:0] r_out_kohm;

    logic             w_div_start;
    logic [DIV_W-1:0] w_div_dividend;
    logic [DIV_W-1:0] w_div_divisor;
    logic             w_div_busy;
    logic [DIV_W-1:0] w_quo;

    logic [15:0]       w_code;
    logic [1:0]        w_sel_last;
    logic [31:0]       w_chan_prod;
    logic [31:0]       w_cq_a;
    logic [31:0]       w_cq_s;
    logic [31:0]       w_cq_a2;
    logic [31:0]       w_cq_s2;
    logic [31:0]       w_cq_sum;
    logic [15:0]       w_chan;
    logic [31:0]       w_raw_prod;
    logic [31:0]       w_prech_prod;
    logic [31:0]       w_heater_prod;
    logic [31:0]       w_gain_prod;
    logic [60:0]       w_recip_prod;
    logic [31:0]       w_scaled;
    logic [31:0]       w_off32;
    logic [31:0]       w_pack_diff;
    logic [VOLT_W-1:0] w_pack;
    logic              w_inhibit;
    logic [31:0]       w_low_prod;
    logic [31:0]       w_high_prod;
    logic [RES_W-1:0]  w_un_hi;
    logic [RES_W-1:0]  w_un_p1;
    logic [RES_W-1:0]  w_up_p1;
    logic [RES_W-1:0]  w_un_side;
    logic [RES_W-1:0]  w_p3_sel;
    logic [RES_W-1:0]  w_lhs;
    logic [46:0]       w_num_prod;
    logic [35:0]       w_den_prod;
    logic [RES_W-1:0]  w_res_sat;
    logic [48:0]       w_fact_prod;
    logic [RES_W-1:0]  w_fact_sat;
    logic [SUM_W-1:0]  w_sum;
    logic [43:0]       w_avg_prod;
    logic [VOLT_W-1:0] w_avg_sat;
    logic [VOLT_W-1:0] w_leak;
    logic              w_emit;

    ibs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // datapath
    always_comb begin
        case (r_sel)
            2'd0:    w_code = r_item.code_a;
            2'd1:    w_code = (r_phase == PH_TOTAL) ? r_item.code_c : r_item.code_b;
            default: w_code = r_item.code_d;
        endcase
    end

    assign w_sel_last    = (r_phase == PH_TOTAL) ? 2'd2 : 2'd1;
    assign w_chan_prod   = w_code * CHAN_FS;

    // divide by 2^n - 1: fold the high part onto the low part twice, then one compare
    assign w_cq_a   = r_chan_prod >> ADC_BITS;
    assign w_cq_s   = w_cq_a + (r_chan_prod & ADC_MASK32);
    assign w_cq_a2  = w_cq_s >> ADC_BITS;
    assign w_cq_s2  = w_cq_a2 + (w_cq_s & ADC_MASK32);
    assign w_cq_sum = w_cq_a + w_cq_a2 + ((w_cq_s2 >= ADC_MASK32) ? 32'd1 : 32'd0);
    assign w_chan   = w_cq_sum[15:0];

    assign w_raw_prod    = r_chan_a * Q_PACK;
    assign w_prech_prod  = r_chan_x * Q_AUX;
    assign w_heater_prod = r_chan_d * Q_AUX;
    assign w_gain_prod   = r_raw * i_gain;
    assign w_recip_prod  = r_gain_prod * PERMILLE_RECIP;

    assign w_scaled    = r_scaled;
    assign w_off32     = {16'd0, i_offset};
    assign w_pack_diff = w_scaled - w_off32;
    always_comb begin
        if (w_scaled < w_off32) begin
            w_pack = '0;
        end else if (|w_pack_diff[31:16]) begin
            w_pack = '1;
        end else begin
            w_pack = w_pack_diff[15:0];
        end
    end
    assign w_inhibit = (w_pack < PACK_MIN) || !i_enable || r_item.ext_inhibit;

    assign w_low_prod  = r_chan_x * Q_LOW;
    assign w_high_prod = r_chan_a * Q_HIGH;

    // low-leg corrections wrap modulo 2^32 on small readings
    assign w_un_hi  = (r_un > UN_HI) ? (r_un - UN_HI_ADJ) : r_un;
    assign w_un_p1  = (w_un_hi < UN_LO) ? (w_un_hi - UN_LO_ADJ) : w_un_hi;
    assign w_up_p1  = r_u2 - w_un_p1;
    assign w_un_side = r_neg_side ? w_un_hi :
                       ((r_un < UN_LO) ? (r_un - UN_LO_ADJ) : r_un);

    assign w_p3_sel   = r_neg_side ? r_unp : r_upp;
    assign w_lhs      = r_p0 + r_p1;
    assign w_num_prod = r_num * SOLVE_NUM;
    assign w_den_prod = r_den * SOLVE_DEN;
    assign w_res_sat  = (|w_quo[DIV_W-1:RES_W]) ? '1 : w_quo[RES_W-1:0];

    assign w_fact_prod = r_pos_leg * factor_q16(r_factor);
    assign w_fact_sat  = w_fact_prod[48] ? '1 : w_fact_prod[47:16];

    assign w_sum      = r_avg_sum + SUM_W'(r_pending);
    assign w_avg_prod = r_avg_fin[18:0] * AVG_RECIP;
    assign w_avg_sat  = (r_avg_fin >= AVG_SAT) ? '1 : w_avg_prod[39:24];
    assign w_leak     = {1'b0, r_leak_out[15:1]} + {1'b0, r_leak_prev[15:1]};

    assign w_emit = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_item_valid) n_state = S_CHAN;
            S_CHAN:      n_state = S_CHAN_WAIT;
            S_CHAN_WAIT: begin
                if (r_sel != w_sel_last) begin
                    n_state = S_CHAN;
                end else if (r_phase == PH_TOTAL) begin
                    n_state = S_P0_SCALE;
                end else begin
                    n_state = S_LEGS;
                end
            end
            S_P0_SCALE:  n_state = S_P0_GAIN;
            S_P0_GAIN:   n_state = S_P0_WAIT;
            S_P0_WAIT:   n_state = S_P0_FIN;
            S_P0_FIN:    n_state = S_EMIT;
            S_LEGS: begin
                unique case (r_phase)
                    PH_BRIDGE:    n_state = S_P1_FIN;
                    PH_REMEASURE: n_state = S_P2_FIN;
                    default:      n_state = S_P3_PREP;
                endcase
            end
            S_P1_FIN:    n_state = S_EMIT;
            S_P2_FIN:    n_state = S_EMIT;
            S_P3_PREP:   n_state = S_P3_MUL;
            S_P3_MUL:    n_state = S_P3_CMP;
            S_P3_CMP:    n_state = S_P3_SOLVE;
            S_P3_SOLVE:  n_state = r_solve ? S_P3_SOLVE_WAIT : S_P3_FACT;
            S_P3_SOLVE_WAIT: if (!w_div_busy) n_state = S_P3_FACT;
            S_P3_FACT:   n_state = S_P3_AVG;
            S_P3_AVG:    n_state = (r_avg_cnt >= AVG_LAST) ? S_P3_AVG_WAIT : S_P3_SMOOTH;
            S_P3_AVG_WAIT: n_state = S_P3_SMOOTH;
            S_P3_SMOOTH: n_state = S_EMIT;
            S_EMIT:      if (w_emit) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: queue pop and divider issue
    always_comb begin
        o_pop          = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = '0;
        w_div_divisor  = '0;
        unique case (r_state)
            S_IDLE: o_pop = i_item_valid;
            S_P3_SOLVE: begin
                w_div_start    = r_solve;
                w_div_dividend = DIV_W'(w_num_prod);
                w_div_divisor  = DIV_W'(w_den_prod);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // state that lives across items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TOTAL;
            r_factor      <= 2'd0;
            r_neg_side    <= 1'b0;
            r_bal_neg     <= '0;
            r_bal_pos     <= '0;
            r_pos_leg     <= '0;
            r_neg_leg     <= '0;
            r_pending     <= '0;
            r_avg_sum     <= '0;
            r_avg_cnt     <= '0;
            r_leak_out    <= LEAK_RESET;
            r_leak_prev   <= PREV_RESET;
            r_held_pack   <= '0;
            r_held_heater <= '0;
            r_held_prech  <= '0;
        end else begin
            unique case (r_state)
                S_P0_SCALE: begin
                    r_held_prech  <= w_prech_prod[31:16];
                    r_held_heater <= w_heater_prod[31:16];
                end
                S_P0_FIN: begin
                    r_held_pack <= w_pack;
                    if (w_pack > F1_LO && w_pack < F1_HI) begin
                        r_factor <= 2'd1;
                    end else if (w_pack > F1_HI && w_pack < F2_HI) begin
                        r_factor <= 2'd2;
                    end
                    if (w_inhibit) begin
                        r_leak_out <= LEAK_INHIBIT;
                        r_avg_sum  <= '0;
                        r_avg_cnt  <= '0;
                    end else begin
                        r_phase <= PH_BRIDGE;
                    end
                end
                S_P1_FIN: begin
                    r_neg_side <= (w_up_p1 < w_un_p1);
                    r_phase    <= PH_REMEASURE;
                end
                S_P2_FIN: begin
                    r_bal_neg <= w_un_side;
                    r_bal_pos <= r_u2 - w_un_side;
                    r_phase   <= PH_LEG;
                end
                S_P3_SOLVE_WAIT: begin
                    if (!w_div_busy) begin
                        if (r_neg_side) begin
                            r_pos_leg <= w_res_sat;
                        end else begin
                            r_neg_leg <= w_res_sat;
                        end
                    end
                end
                S_P3_FACT: begin
                    if (r_neg_side) begin
                        r_pending <= w_fact_sat;
                    end else if (r_rise) begin
                        r_pending <= r_neg_leg;
                    end
                end
                S_P3_AVG: begin
                    if (r_avg_cnt >= AVG_LAST) begin
                        r_avg_sum <= '0;
                        r_avg_cnt <= '0;
                    end else begin
                        r_avg_sum <= w_sum;
                        r_avg_cnt <= r_avg_cnt + 1'b1;
                    end
                end
                S_P3_AVG_WAIT: r_leak_out <= w_avg_sat;
                S_P3_SMOOTH: begin
                    r_leak_out  <= w_leak;
                    r_leak_prev <= w_leak;
                    r_phase     <= PH_TOTAL;
                end
                default: ;
            endcase
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item <= i_item;
                r_done <= r_phase;
                r_sel  <= 2'd0;
            end
            S_CHAN: r_chan_prod <= w_chan_prod;
            S_CHAN_WAIT: begin
                case (r_sel)
                    2'd0:    r_chan_a <= w_chan;
                    2'd1:    r_chan_x <= w_chan;
                    default: r_chan_d <= w_chan;
                endcase
                r_sel <= r_sel + 1'b1;
            end
            S_P0_SCALE: r_raw <= w_raw_prod[31:16];
            S_P0_GAIN:  r_gain_prod <= w_gain_prod;
            S_P0_WAIT:  r_scaled <= 32'(w_recip_prod >> PERMILLE_SHIFT);
            S_P0_FIN:   r_relay <= w_inhibit ? RELAY_OPEN : RELAY_BRIDGE;
            S_LEGS: begin
                r_un <= {16'd0, w_low_prod[31:16]};
                r_u2 <= {16'd0, w_high_prod[31:16]};
            end
            S_P1_FIN:   r_relay <= RELAY_BRIDGE;
            S_P2_FIN:   r_relay <= r_neg_side ? RELAY_NEG : RELAY_POS;
            S_P3_PREP: begin
                r_unp  <= w_un_side;
                r_upp  <= r_u2 - w_un_side;
                r_rise <= (r_u2 > w_un_side);
            end
            S_P3_MUL: begin
                r_p0 <= r_bal_neg * w_p3_sel;
                r_p1 <= r_bal_pos * w_p3_sel;
                r_p2 <= r_neg_side ? (r_bal_neg * r_upp) : (r_bal_pos * r_unp);
            end
            S_P3_CMP: begin
                r_num   <= r_neg_side ? (r_p2 - r_p1) : (r_p2 - r_p0);
                r_den   <= w_lhs - r_p2;
                r_solve <= (w_lhs != r_p2) && (r_neg_side || r_rise);
            end
            S_P3_AVG: begin
                if (r_avg_cnt >= AVG_LAST) begin
                    r_avg_fin <= w_sum;
                end
            end
            S_P3_SMOOTH: r_relay <= RELAY_OPEN;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_relay  <= r_relay;
            r_out_phase  <= r_done;
            r_out_pack   <= r_held_pack;
            r_out_heater <= r_held_heater;
            r_out_prech  <= r_held_prech;
            r_out_kohm   <= r_leak_out;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.relay_pattern     = r_out_relay;
    assign o_out.phase_done        = r_out_phase;
    assign o_out.pack_voltage      = r_out_pack;
    assign o_out.heater_voltage    = r_out_heater;
    assign o_out.precharge_voltage = r_out_prech;
    assign o_out.insulation_kohm   = r_out_kohm;

endmodule
